[src/dssa_pkg.sv]
// Shared types and constants for the dual stack unit.
`timescale 1ns / 1ps
`default_nettype none
package dssa_pkg;

    localparam int DEPTH      = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    localparam logic SEL_LOW  = 1'b0;
    localparam logic SEL_HIGH = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

endpackage
`default_nettype wire

[src/dssa_ram.sv]
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module dssa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule
`default_nettype wire

[src/dual_stack_shared_array_unit.sv]
// Top level: two LIFO stacks growing toward each other in one shared RAM.
//
//  Channel   Direction  Payload
//  s_        in         tdata = push_value; tuser = func, stack_sel
//  m_        out        tdata = pop_value;  tuser = status
//
// The result of a push or a refused operation is registered at the edge that accepts it.
// A successful pop passes through S_POP_READ for the registered RAM read data.
// One operation is in flight at a time; the output register lets the next transaction
// be accepted in the same cycle that the previous result is taken.
// Synchronous reset empties both stacks; RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module dual_stack_shared_array_unit
    import dssa_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] push_value
    input  wire logic [1:0]            s_tuser,   // [0] func, [1] stack_sel

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // [31:0] pop_value
    output logic [1:0]                 m_tuser    // [1:0] status
);

    typedef enum logic {
        S_IDLE,
        S_POP_READ
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      low_cnt_reg, low_cnt_next;
    logic [CNT_W-1:0]      high_cnt_reg, high_cnt_next;
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;
    status_t               m_status_reg, m_status_next;

    logic                  accept;
    logic                  op_push;
    logic                  sel;
    logic [CNT_W-1:0]      cur_cnt;
    logic [CNT_W-1:0]      cnt_m1;
    logic [CNT_W:0]        cnt_sum;
    logic                  is_full;
    logic                  is_empty;
    logic [ADDR_W-1:0]     pos;
    logic [ADDR_W-1:0]     ram_addr;
    logic                  ram_we;
    logic                  ram_en;
    logic [DATA_WIDTH-1:0] ram_rdata;

    assign s_tready = (state_reg == S_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign op_push  = (s_tuser[0] == FUNC_PUSH);
    assign sel      = s_tuser[1];
    assign cur_cnt  = (sel == SEL_HIGH) ? high_cnt_reg : low_cnt_reg;
    assign cnt_m1   = cur_cnt - CNT_W'(1);
    assign cnt_sum  = {1'b0, low_cnt_reg} + {1'b0, high_cnt_reg};
    assign is_full  = (cnt_sum >= (CNT_W + 1)'(DEPTH));
    assign is_empty = (cur_cnt == '0);

    // A push writes at the current count, a pop reads one below it; the high stack mirrors.
    assign pos      = op_push ? cur_cnt[ADDR_W-1:0] : cnt_m1[ADDR_W-1:0];
    assign ram_addr = (sel == SEL_HIGH) ? (ADDR_W'(DEPTH - 1) - pos) : pos;
    assign ram_we   = accept && op_push && !is_full;
    assign ram_en   = ram_we || (accept && !op_push && !is_empty);

    dssa_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (DATA_WIDTH'(s_tdata)),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        low_cnt_next  = low_cnt_reg;
        high_cnt_next = high_cnt_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (op_push) begin
                        m_valid_next  = 1'b1;
                        m_data_next   = '0;
                        m_status_next = is_full ? ST_FULL : ST_DONE;
                        if (!is_full) begin
                            if (sel == SEL_HIGH) begin
                                high_cnt_next = cur_cnt + CNT_W'(1);
                            end else begin
                                low_cnt_next = cur_cnt + CNT_W'(1);
                            end
                        end
                    end else if (is_empty) begin
                        m_valid_next  = 1'b1;
                        m_data_next   = '0;
                        m_status_next = ST_EMPTY;
                    end else begin
                        if (sel == SEL_HIGH) begin
                            high_cnt_next = cnt_m1;
                        end else begin
                            low_cnt_next = cnt_m1;
                        end
                        state_next = S_POP_READ;
                    end
                end
            end
            S_POP_READ: begin
                // The output register was free when the pop was accepted.
                m_valid_next  = 1'b1;
                m_data_next   = OUT_DATA_W'(ram_rdata);
                m_status_next = ST_DONE;
                state_next    = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            low_cnt_reg  <= '0;
            high_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            low_cnt_reg  <= low_cnt_next;
            high_cnt_reg <= high_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

endmodule
`default_nettype wire

[dv/dual_stack_checker.sv]
// Checker for the dual stack unit: mirrors both stacks, predicts each result and compares.
`timescale 1ns / 1ps
module dual_stack_checker
    import dssa_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] push_value
    input  wire logic [1:0]            s_tuser,   // [0] func, [1] stack_sel
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata,   // [31:0] pop_value
    input  wire logic [1:0]            m_tuser,   // [1:0] status
    output int                         fail_count,
    output int                         pending
);

    typedef struct packed {
        logic [DATA_WIDTH-1:0] pop_value;
        status_t               status;
    } stack_result_t;

    logic [DATA_WIDTH-1:0] shadow_mem [DEPTH];
    logic [CNT_W-1:0]      low_count;
    logic [CNT_W-1:0]      high_count;
    stack_result_t         expected_results [$];
    int                    mismatches = 0;
    int                    queued = 0;

    assign fail_count = mismatches;
    assign pending    = queued;

    // The low stack grows up from address zero, the high stack down from the last word.
    function automatic logic [ADDR_W-1:0] slot_addr(input logic sel, input logic [CNT_W-1:0] pos);
        if (sel == SEL_HIGH) begin
            return ADDR_W'(DEPTH - 1 - int'(pos));
        end
        return ADDR_W'(pos);
    endfunction

    // Applies one operation to the mirrored stacks and returns the result it should give.
    function automatic stack_result_t apply_stack_op(input logic op, input logic sel,
                                                     input logic [IN_DATA_W-1:0] word);
        stack_result_t    res;
        logic [CNT_W-1:0] cnt;
        res.pop_value = '0;
        res.status    = ST_DONE;
        cnt = (sel == SEL_HIGH) ? high_count : low_count;
        if (op == FUNC_PUSH) begin
            if (int'(low_count) + int'(high_count) >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                shadow_mem[slot_addr(sel, cnt)] = word[DATA_WIDTH-1:0];
                cnt = cnt + CNT_W'(1);
            end
        end else begin
            if (cnt == '0) begin
                res.status = ST_EMPTY;
            end else begin
                cnt = cnt - CNT_W'(1);
                res.pop_value = shadow_mem[slot_addr(sel, cnt)];
            end
        end
        if (sel == SEL_HIGH) begin
            high_count = cnt;
        end else begin
            low_count = cnt;
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        stack_result_t want;
        if (!aresetn) begin
            low_count  = '0;
            high_count = '0;
            expected_results.delete();
        end else begin
            // Results are matched before new transactions are queued, so a result can
            // never be paired with a transaction accepted at the same edge.
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: pop_value %h status %0d", m_tdata, m_tuser);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata !== want.pop_value) begin
                        $error("pop_value expected %h actual %h", want.pop_value, m_tdata);
                        mismatches++;
                    end
                    if (m_tuser !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, m_tuser);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_results.push_back(apply_stack_op(s_tuser[0], s_tuser[1], s_tdata));
            end
        end
        queued <= expected_results.size();
    end

endmodule

[dv/testbench.sv]
// Top of the dual stack testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module testbench;
    import dssa_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MODE_ITEMS    = 200;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;   // [31:0] push_value
    logic [1:0]            s_tuser = '0;   // [0] func, [1] stack_sel
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // [31:0] pop_value
    logic [1:0]            m_tuser;        // [1:0] status

    int         fail_count;
    int         pending;
    idle_mode_t idle_mode = IDLE_NONE;
    int         sent_count = 0;
    int         quiet_cycles = 0;
    // Occupancy as the stimulus sees it; only used to steer toward full and empty.
    int         low_used = 0;
    int         high_used = 0;

    always #5 aclk = ~aclk;

    dual_stack_shared_array_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    dual_stack_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge aclk) begin
        case (idle_mode)
            IDLE_RECEIVER: m_tready <= ($urandom_range(99) >= 45);
            IDLE_BOTH:     m_tready <= ($urandom_range(99) >= 32);
            default:       m_tready <= 1'b1;
        endcase
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Drives one transaction, with a random gap ahead of it, and returns at the edge
    // where it is accepted.
    task automatic send_op(input logic op, input logic sel, input logic [IN_DATA_W-1:0] word);
        int         gap;
        int         idle_pct;
        idle_mode_t mode;
        gap = 0;
        mode = idle_mode_t'((sent_count / MODE_ITEMS) % 4);
        idle_mode <= mode;
        idle_pct = (mode == IDLE_SENDER) ? 45 : (mode == IDLE_BOTH) ? 32 : 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= {sel, op};
        do @(posedge aclk); while (!s_tready);
        sent_count++;
        if (op == FUNC_PUSH) begin
            if (low_used + high_used < DEPTH) begin
                if (sel == SEL_HIGH) high_used++;
                else low_used++;
            end
        end else if (sel == SEL_HIGH) begin
            if (high_used > 0) high_used--;
        end else if (low_used > 0) begin
            low_used--;
        end
    endtask

    // The checker's count is registered, so it is read only after the next edge.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        int  full_refusals;
        logic op;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty pops on both stacks; the data word must be ignored.
        send_op(FUNC_POP,  SEL_LOW,  32'h0000_0000);
        send_op(FUNC_POP,  SEL_HIGH, 32'hFFFF_FFFF);
        // Extreme words on both stacks, then popped back in LIFO order past empty.
        send_op(FUNC_PUSH, SEL_LOW,  32'h0000_0000);
        send_op(FUNC_PUSH, SEL_LOW,  32'hFFFF_FFFF);
        send_op(FUNC_PUSH, SEL_HIGH, 32'hFFFF_FFFF);
        send_op(FUNC_PUSH, SEL_HIGH, 32'h0000_0000);
        send_op(FUNC_POP,  SEL_HIGH, 32'h1234_5678);
        send_op(FUNC_POP,  SEL_HIGH, 32'h0000_0000);
        send_op(FUNC_POP,  SEL_HIGH, 32'h0000_0000);
        send_op(FUNC_POP,  SEL_LOW,  32'hFFFF_FFFF);
        send_op(FUNC_POP,  SEL_LOW,  32'h0000_0000);
        send_op(FUNC_POP,  SEL_LOW,  32'h0000_0000);
        // A pop right behind the push it reads reads a word that the push has just written.
        send_op(FUNC_PUSH, SEL_LOW,  32'h0000_0001);
        send_op(FUNC_POP,  SEL_LOW,  32'h0000_0000);
        send_op(FUNC_PUSH, SEL_HIGH, 32'h8000_0000);
        send_op(FUNC_POP,  SEL_HIGH, 32'h0000_0000);
        send_op(FUNC_PUSH, SEL_LOW,  32'hA5A5_A5A5);
        send_op(FUNC_PUSH, SEL_HIGH, 32'h5A5A_5A5A);
        send_op(FUNC_POP,  SEL_LOW,  32'hFFFF_FFFF);
        send_op(FUNC_POP,  SEL_HIGH, 32'hFFFF_FFFF);
        wait_for_results();

        // Mostly pushes until the stacks meet, then keep hitting the full condition.
        full_refusals = 0;
        while (full_refusals < 40) begin
            op = ($urandom_range(99) < 10) ? FUNC_POP : FUNC_PUSH;
            if (op == FUNC_PUSH && low_used + high_used >= DEPTH) full_refusals++;
            send_op(op, 1'($urandom_range(1)), $urandom());
        end
        wait_for_results();

        // Mostly pops, unwinding both stacks from the full state.
        repeat (220) begin
            op = ($urandom_range(99) < 80) ? FUNC_POP : FUNC_PUSH;
            send_op(op, 1'($urandom_range(1)), $urandom());
        end
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (pending != 0) begin
            $error("%0d expected results never arrived", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
